@@ hw/rtl/gte_pkg.sv @@
// ----------------------------------------------------------------------------
// gte_pkg: shared types, constants and constant functions
// Fixed-point constants for the geodetic to ENU converter (Q61 angles and
// trig values, Q16 millimetre lengths) and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gte_pkg;

  typedef logic signed [63:0] q_t;

  typedef struct packed {
    logic signed [35:0] val;
    logic               sat;
  } fin_t;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int NEWTON_STEPS      = 8;

  localparam q_t Q61_ONE   = 64'sh2000_0000_0000_0000;
  localparam q_t Q61_THREE = 64'sh6000_0000_0000_0000;
  localparam q_t PI_Q61    = 64'sh6487_ED51_10B4_611A;
  localparam q_t A_Q16     = 64'sd6378137000 * 64'sd65536;
  localparam q_t OUT_LIMIT = 64'sd20000000000;
  localparam q_t RND_HALF  = 64'sd32768;

  // starting guess 0.6 for the CORDIC gain iteration
  localparam q_t GAIN_SEED = (Q61_ONE / 10) * 6;

  localparam logic [127:0] INV_F_E9 = 128'd298257223563;

  localparam logic signed [32:0] DEG_HALF_TURN = 33'sd1800000000;
  localparam logic signed [32:0] DEG_QUARTER   = 33'sd900000000;

  // floor(2^64 * pi_q61 / 1.8e9) + 1: exact floor for magnitudes below 2^30
  localparam logic [127:0] RAD_RECIP =
    ((128'(PI_Q61) << 64) / 128'(DEG_HALF_TURN)) + 128'd1;

  // (a*b) >> sh with magnitude truncation and int64 saturation
  function automatic q_t f_mulshr(input q_t a, input q_t b, input int sh);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] pr;
    logic [127:0] r;
    logic         neg;
    neg = a[63] ^ b[63];
    ma  = a[63] ? 64'(-a) : 64'(a);
    mb  = b[63] ? 64'(-b) : 64'(b);
    pr  = {64'd0, ma} * {64'd0, mb};
    r   = pr >> sh;
    if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -q_t'(r[63:0]) : q_t'(r[63:0]);
  endfunction

  // truncating quotient of a non-negative value, long division at elaboration
  function automatic q_t f_udiv(input q_t num, input int den);
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dv;
    dv  = 64'(den);
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = {quo[62:0], 1'b0};
      if (rem >= dv) begin
        rem    = rem - dv;
        quo[0] = 1'b1;
      end
    end
    return q_t'(quo);
  endfunction

  function automatic q_t f_rsqrt(input q_t p, input q_t y0);
    q_t y;
    q_t t;
    y = y0;
    for (int k = 0; k < NEWTON_STEPS; k++) begin
      t = f_mulshr(y, y, 61);
      t = f_mulshr(p, t, 61);
      t = Q61_THREE - t;
      y = f_mulshr(y, t, 62);
    end
    return y;
  endfunction

  function automatic q_t f_cordic_gain(input int n);
    q_t p;
    p = Q61_ONE;
    for (int i = 0; i < n; i++) p = p + (p >>> (2 * i));
    return f_rsqrt(p, GAIN_SEED);
  endfunction

  // arctan(2^-i) in Q61 from the alternating series
  function automatic q_t f_atan(input int i);
    q_t sum;
    q_t term;
    int k;
    int sh;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q61 >>> 2;
    end else begin
      k  = 0;
      sh = i;
      while (sh <= 61) begin
        term = f_udiv(Q61_ONE >>> sh, 2 * k + 1);
        sum  = k[0] ? sum - term : sum + term;
        k    = k + 1;
        sh   = i * (2 * k + 1);
      end
    end
    return sum;
  endfunction

  localparam q_t FLAT_Q61 = q_t'(((128'd1 << 61) * 128'd1000000000) / INV_F_E9);
  localparam q_t E2_Q61   = 2 * FLAT_Q61 - f_mulshr(FLAT_Q61, FLAT_Q61, 61);
  localparam q_t ONE_M_E2 = Q61_ONE - E2_Q61;

  // round Q16 to mm and clamp to the output range
  function automatic fin_t f_finish(input q_t v);
    fin_t f;
    q_t   r;
    r     = (v + RND_HALF) >>> 16;
    f.sat = 1'b0;
    if (r > OUT_LIMIT) begin
      r     = OUT_LIMIT;
      f.sat = 1'b1;
    end
    if (r < -OUT_LIMIT) begin
      r     = -OUT_LIMIT;
      f.sat = 1'b1;
    end
    f.val = r[35:0];
    return f;
  endfunction

endpackage

@@ hw/rtl/geodetic_to_enu_converter_unit.sv @@
// ----------------------------------------------------------------------------
// geodetic_to_enu_converter_unit: WGS84 geodetic point to local ENU
// The pipeline depth is set by the CORDIC cell chain and the eight Newton
//   steps of the radius calculation.
// Throughput: one point per cycle; the whole pipeline holds while a result
//   waits at the output register.
// Reset: clears all valid flags and loads the default origin registers.
// ----------------------------------------------------------------------------
module geodetic_to_enu_converter_unit #(
  parameter int CORDIC_STAGES = gte_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input point
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // point_lat[30:0], point_lon[62:31], point_alt[90:63]
  // result
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // east_mm[35:0], north_mm[71:36], up_mm[107:72]
  output logic         m_tuser,   // saturated
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import gte_pkg::*;

  localparam logic [1:0] REG_ORIGIN_LAT = 2'd0;
  localparam logic [1:0] REG_ORIGIN_LON = 2'd1;
  localparam logic [1:0] REG_ORIGIN_ALT = 2'd2;

  localparam int LANE_LAT = 3 + CORDIC_STAGES + 58;
  localparam int TOT      = LANE_LAT + 5;

  logic signed [30:0] origin_lat;
  logic signed [31:0] origin_lon;
  logic signed [27:0] origin_alt;
  logic [TOT-1:0]     vld;
  logic               en;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_lat <= 31'sd374496400;
      origin_lon <= 32'sd1266566100;
      origin_alt <= 28'sd147674;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ORIGIN_LAT: origin_lat <= pwdata[30:0];
        REG_ORIGIN_LON: origin_lon <= pwdata;
        REG_ORIGIN_ALT: origin_alt <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ORIGIN_LAT: prdata = 32'(origin_lat);
      REG_ORIGIN_LON: prdata = origin_lon;
      REG_ORIGIN_ALT: prdata = 32'(origin_alt);
      default:        prdata = '0;
    endcase
  end

  // pipeline advance and valid tracking
  assign en       = !vld[TOT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOT-2:0], s_tvalid};
  end

  // point and origin lanes
  q_t p_sl, p_cl, p_so, p_co, p_x, p_y, p_z;
  q_t o_sl, o_cl, o_so, o_co, o_x, o_y, o_z;

  gte_ecef #(.CORDIC_STAGES(CORDIC_STAGES)) u_pt (
    .clk(clk), .en(en),
    .lat(s_tdata[30:0]), .lon(s_tdata[62:31]), .alt(s_tdata[90:63]),
    .sl(p_sl), .cl(p_cl), .so(p_so), .co(p_co), .x(p_x), .y(p_y), .z(p_z)
  );

  gte_ecef #(.CORDIC_STAGES(CORDIC_STAGES)) u_org (
    .clk(clk), .en(en),
    .lat(origin_lat), .lon(origin_lon), .alt(origin_alt),
    .sl(o_sl), .cl(o_cl), .so(o_so), .co(o_co), .x(o_x), .y(o_y), .z(o_z)
  );

  // rotate the difference into the local frame
  q_t dx, dy, dz, dz2, ocl2, osl2;
  q_t ma, mb, mc, md, t, e, e2d;
  q_t me, mf, mg, mh, n, u;

  assign dx = p_x - o_x;
  assign dy = p_y - o_y;
  assign dz = p_z - o_z;

  gte_mul #(.SH(61)) u_ma (.clk(clk), .en(en), .a(dx), .b(o_co), .p(ma));
  gte_mul #(.SH(61)) u_mb (.clk(clk), .en(en), .a(dy), .b(o_so), .p(mb));
  gte_mul #(.SH(61)) u_mc (.clk(clk), .en(en), .a(dy), .b(o_co), .p(mc));
  gte_mul #(.SH(61)) u_md (.clk(clk), .en(en), .a(dx), .b(o_so), .p(md));
  gte_dly #(.W(64), .N(2)) u_dz  (.clk(clk), .en(en), .d(dz),   .q(dz2));
  gte_dly #(.W(64), .N(2)) u_ocl (.clk(clk), .en(en), .d(o_cl), .q(ocl2));
  gte_dly #(.W(64), .N(2)) u_osl (.clk(clk), .en(en), .d(o_sl), .q(osl2));

  assign t = ma + mb;
  assign e = mc - md;

  gte_mul #(.SH(61)) u_me (.clk(clk), .en(en), .a(dz2), .b(ocl2), .p(me));
  gte_mul #(.SH(61)) u_mf (.clk(clk), .en(en), .a(t),   .b(osl2), .p(mf));
  gte_mul #(.SH(61)) u_mg (.clk(clk), .en(en), .a(t),   .b(ocl2), .p(mg));
  gte_mul #(.SH(61)) u_mh (.clk(clk), .en(en), .a(dz2), .b(osl2), .p(mh));
  gte_dly #(.W(64), .N(2)) u_e (.clk(clk), .en(en), .d(e), .q(e2d));

  assign n = me - mf;
  assign u = mg + mh;

  // round, clamp and register the result
  fin_t fe, fn, fu;
  assign fe = f_finish(e2d);
  assign fn = f_finish(n);
  assign fu = f_finish(u);

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'd0, fu.val, fn.val, fe.val};
      m_tuser <= fe.sat | fn.sat | fu.sat;
    end
  end

  // checks
  localparam logic signed [35:0] LIM = 36'sd20000000000;

  a_east_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[35:0]) <= LIM && $signed(m_tdata[35:0]) >= -LIM))
    else $error("east out of range");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      ($signed(m_tdata[35:0]) == LIM || $signed(m_tdata[35:0]) == -LIM ||
       $signed(m_tdata[71:36]) == LIM || $signed(m_tdata[71:36]) == -LIM ||
       $signed(m_tdata[107:72]) == LIM || $signed(m_tdata[107:72]) == -LIM))
    else $error("saturation flag without clamped field");

  a_accept_tracked: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted point not tracked");

endmodule

@@ hw/rtl/gte_dly.sv @@
// ----------------------------------------------------------------------------
// gte_dly: stallable delay line
// Holds a value for N pipeline advances to line it up with other paths.
// ----------------------------------------------------------------------------
module gte_dly #(
  parameter int W = 64,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  // shift on every pipeline advance
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

@@ hw/rtl/gte_mul.sv @@
// ----------------------------------------------------------------------------
// gte_mul: two-stage signed fixed-point multiplier
// 64x64 magnitude product from four 32x32 partial products, shifted right by
// SH with truncation toward zero and saturation to the signed 64-bit range.
// ----------------------------------------------------------------------------
module gte_mul #(
  parameter int SH = 61
) (
  input  logic          clk,
  input  logic          en,
  input  gte_pkg::q_t   a,
  input  gte_pkg::q_t   b,
  output gte_pkg::q_t   p
);
  import gte_pkg::*;

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [63:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic         neg;
  logic [127:0] sum;
  logic [127:0] r;
  logic [63:0]  rs;

  assign ma = a[63] ? 64'(-a) : 64'(a);
  assign mb = b[63] ? 64'(-b) : 64'(b);

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg   <= a[63] ^ b[63];
      pp_ll <= 64'(ma[31:0])  * 64'(mb[31:0]);
      pp_lh <= 64'(ma[31:0])  * 64'(mb[63:32]);
      pp_hl <= 64'(ma[63:32]) * 64'(mb[31:0]);
      pp_hh <= 64'(ma[63:32]) * 64'(mb[63:32]);
    end
  end

  // stage 2: accumulate, shift, saturate, sign
  always_comb begin
    sum = {64'd0, pp_ll} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
        + {pp_hh, 64'd0};
    r   = sum >> SH;
    rs  = (|r[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : r[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) p <= neg ? -q_t'(rs) : q_t'(rs);
  end

endmodule

@@ hw/rtl/gte_cell.sv @@
// ----------------------------------------------------------------------------
// gte_cell: one CORDIC rotation cell
// Rotates (x, y) by +-atan(2^-IDX) toward z = 0 and passes the result on.
// ----------------------------------------------------------------------------
module gte_cell #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        en,
  input  gte_pkg::q_t x_in,
  input  gte_pkg::q_t y_in,
  input  gte_pkg::q_t z_in,
  input  logic        flip_in,
  output gte_pkg::q_t x,
  output gte_pkg::q_t y,
  output gte_pkg::q_t z,
  output logic        flip
);
  import gte_pkg::*;

  localparam q_t ATAN = f_atan(IDX);

  q_t dx;
  q_t dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  // rotate by the sign of the residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      flip <= flip_in;
      if (!z_in[63]) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
    end
  end

endmodule

@@ hw/rtl/gte_ecef.sv @@
// ----------------------------------------------------------------------------
// gte_ecef: geodetic to earth-centred lane
// Angle reduction and degree to radian scaling, two CORDIC cell chains for
// latitude and longitude, prime-vertical radius by pipelined Newton steps,
// then the X, Y, Z products.
// ----------------------------------------------------------------------------
module gte_ecef #(
  parameter int CORDIC_STAGES = gte_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [30:0] lat,
  input  logic signed [31:0] lon,
  input  logic signed [27:0] alt,
  output gte_pkg::q_t        sl,
  output gte_pkg::q_t        cl,
  output gte_pkg::q_t        so,
  output gte_pkg::q_t        co,
  output gte_pkg::q_t        x,
  output gte_pkg::q_t        y,
  output gte_pkg::q_t        z
);
  import gte_pkg::*;

  localparam q_t GAIN = f_cordic_gain(CORDIC_STAGES);
  localparam int T0   = 3 + CORDIC_STAGES;

  logic signed [32:0] ang [2];
  q_t sn [2];
  q_t cs [2];

  assign ang[0] = 33'(lat);
  assign ang[1] = 33'(lon);

  // sine and cosine of latitude (0) and longitude (1)
  for (genvar g = 0; g < 2; g++) begin : g_ang
    logic signed [32:0] red;
    logic               flip1, flip2, flip3, neg2;
    logic [32:0]        mag_full;
    logic [61:0]        pp0, pp1, pp2;
    logic [127:0]       acc;
    q_t                 z0;
    q_t                 cx [CORDIC_STAGES+1];
    q_t                 cy [CORDIC_STAGES+1];
    q_t                 cz [CORDIC_STAGES+1];
    logic               cf [CORDIC_STAGES+1];

    // fold angles beyond a quarter turn
    always_ff @(posedge clk) begin
      if (en) begin
        if (ang[g] > DEG_QUARTER) begin
          red   <= DEG_HALF_TURN - ang[g];
          flip1 <= 1'b1;
        end else if (ang[g] < -DEG_QUARTER) begin
          red   <= -DEG_HALF_TURN - ang[g];
          flip1 <= 1'b1;
        end else begin
          red   <= ang[g];
          flip1 <= 1'b0;
        end
      end
    end

    // degrees to radians: magnitude times reciprocal, three limbs
    assign mag_full = red[32] ? 33'(-red) : 33'(red);

    always_ff @(posedge clk) begin
      if (en) begin
        neg2  <= red[32];
        flip2 <= flip1;
        pp0   <= 62'(mag_full[29:0]) * 62'(RAD_RECIP[31:0]);
        pp1   <= 62'(mag_full[29:0]) * 62'(RAD_RECIP[63:32]);
        pp2   <= 62'(mag_full[29:0]) * 62'(RAD_RECIP[95:64]);
      end
    end

    assign acc = {66'd0, pp0} + {34'd0, pp1, 32'd0} + {2'd0, pp2, 64'd0};

    always_ff @(posedge clk) begin
      if (en) begin
        flip3 <= flip2;
        z0    <= neg2 ? -q_t'(acc[127:64]) : q_t'(acc[127:64]);
      end
    end

    assign cx[0] = GAIN;
    assign cy[0] = '0;
    assign cz[0] = z0;
    assign cf[0] = flip3;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      gte_cell #(.IDX(i)) u_cell (
        .clk(clk), .en(en),
        .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .flip_in(cf[i]),
        .x(cx[i+1]), .y(cy[i+1]), .z(cz[i+1]), .flip(cf[i+1])
      );
    end

    assign sn[g] = cy[CORDIC_STAGES];
    assign cs[g] = cf[CORDIC_STAGES] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
  end

  // w = 1 - e2 sin^2(lat)
  q_t ss, es, w;
  gte_mul #(.SH(61)) u_ss (.clk(clk), .en(en), .a(sn[0]), .b(sn[0]), .p(ss));
  gte_mul #(.SH(61)) u_es (.clk(clk), .en(en), .a(E2_Q61), .b(ss), .p(es));
  assign w = Q61_ONE - es;

  // 1/sqrt(w): Newton steps y = y(3 - w y^2)/2
  q_t ny [NEWTON_STEPS+1];
  q_t np [NEWTON_STEPS+1];
  assign ny[0] = Q61_ONE;
  assign np[0] = w;

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
    q_t t1, t2, t3, yd, pd;
    gte_dly #(.W(64), .N(4)) u_yd (.clk(clk), .en(en), .d(ny[k]), .q(yd));
    gte_dly #(.W(64), .N(2)) u_pd (.clk(clk), .en(en), .d(np[k]), .q(pd));
    gte_mul #(.SH(61)) u_m1 (.clk(clk), .en(en), .a(ny[k]), .b(ny[k]), .p(t1));
    gte_mul #(.SH(61)) u_m2 (.clk(clk), .en(en), .a(pd), .b(t1), .p(t2));
    assign t3 = Q61_THREE - t2;
    gte_mul #(.SH(62)) u_m3 (.clk(clk), .en(en), .a(yd), .b(t3), .p(ny[k+1]));
    gte_dly #(.W(64), .N(4)) u_pn (.clk(clk), .en(en), .d(pd), .q(np[k+1]));
  end

  // aligned trig values and heights
  q_t cl54, sl56, so56, co56;
  logic [27:0] alt54, alt56;
  q_t h54, h56;

  gte_dly #(.W(64), .N(54)) u_cl54 (.clk(clk), .en(en), .d(cs[0]), .q(cl54));
  gte_dly #(.W(64), .N(4))  u_cl58 (.clk(clk), .en(en), .d(cl54), .q(cl));
  gte_dly #(.W(64), .N(56)) u_sl56 (.clk(clk), .en(en), .d(sn[0]), .q(sl56));
  gte_dly #(.W(64), .N(2))  u_sl58 (.clk(clk), .en(en), .d(sl56), .q(sl));
  gte_dly #(.W(64), .N(56)) u_so56 (.clk(clk), .en(en), .d(sn[1]), .q(so56));
  gte_dly #(.W(64), .N(2))  u_so58 (.clk(clk), .en(en), .d(so56), .q(so));
  gte_dly #(.W(64), .N(56)) u_co56 (.clk(clk), .en(en), .d(cs[1]), .q(co56));
  gte_dly #(.W(64), .N(2))  u_co58 (.clk(clk), .en(en), .d(co56), .q(co));
  gte_dly #(.W(28), .N(T0 + 54)) u_a54 (.clk(clk), .en(en), .d(alt), .q(alt54));
  gte_dly #(.W(28), .N(2))       u_a56 (.clk(clk), .en(en), .d(alt54), .q(alt56));

  assign h54 = q_t'($signed(alt54)) <<< 16;
  assign h56 = q_t'($signed(alt56)) <<< 16;

  // radius and earth-centred coordinates
  q_t nrad, q, nz;
  gte_mul #(.SH(61)) u_nr (.clk(clk), .en(en), .a(A_Q16), .b(ny[NEWTON_STEPS]),
                           .p(nrad));
  gte_mul #(.SH(61)) u_q  (.clk(clk), .en(en), .a(nrad + h54), .b(cl54), .p(q));
  gte_mul #(.SH(61)) u_nz (.clk(clk), .en(en), .a(nrad), .b(ONE_M_E2), .p(nz));
  gte_mul #(.SH(61)) u_x  (.clk(clk), .en(en), .a(q), .b(co56), .p(x));
  gte_mul #(.SH(61)) u_y  (.clk(clk), .en(en), .a(q), .b(so56), .p(y));
  gte_mul #(.SH(61)) u_z  (.clk(clk), .en(en), .a(nz + h56), .b(sl56), .p(z));

endmodule

@@ verif/enu_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enu_result_checker: result predictor and scoreboard for the ENU converter
// Watches the point, result and configuration channels. Each accepted point
// is converted to East/North/Up with a bit-exact fixed-point model, and each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module enu_result_checker #(
  parameter int         STAGES   = 32,
  parameter logic [3:0] ADDR_LAT = 4'd0,
  parameter logic [3:0] ADDR_LON = 4'd4,
  parameter logic [3:0] ADDR_ALT = 4'd8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           pending,
  output int           errors
);

  typedef logic signed [63:0] fx_t;

  typedef struct {
    logic signed [35:0] east;
    logic signed [35:0] north;
    logic signed [35:0] up;
    logic               sat;
  } enu_t;

  typedef struct {
    fx_t sl, cl, so, co;
    fx_t x, y, z;
  } ecef_t;

  localparam fx_t ONE       = 64'sh2000_0000_0000_0000;
  localparam fx_t PI        = 64'sh6487_ED51_10B4_611A;
  localparam fx_t SEMI_MAJ  = 64'sd6378137000 * 64'sd65536;
  localparam fx_t LIMIT_MM  = 64'sd20000000000;
  localparam fx_t HALF_TURN = 64'sd1800000000;
  localparam fx_t QUARTER   = 64'sd900000000;

  fx_t  atan_q[STAGES];
  fx_t  gain_q;
  fx_t  ecc2_q;
  fx_t  org_lat, org_lon, org_alt;
  enu_t enu_queue[$];

  // magnitude product, truncated shift, saturated to 64 bits
  function automatic fx_t mul_q(input fx_t a, input fx_t b, input int sh);
    logic [63:0]  ma, mb;
    logic [127:0] r;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    r  = ({64'd0, ma} * {64'd0, mb}) >> sh;
    if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
    return (a[63] ^ b[63]) ? -fx_t'(r[63:0]) : fx_t'(r[63:0]);
  endfunction

  // eight Newton steps toward 1/sqrt(p)
  function automatic fx_t inv_sqrt(input fx_t p, input fx_t y0);
    fx_t y, t;
    y = y0;
    for (int k = 0; k < 8; k++) begin
      t = mul_q(p, mul_q(y, y, 61), 61);
      y = mul_q(y, 3 * ONE - t, 62);
    end
    return y;
  endfunction

  function automatic fx_t deg_to_q61(input fx_t d);
    logic [127:0] m;
    m = d[63] ? 128'(-d) : 128'(d);
    m = (m * 128'(PI)) / 128'(HALF_TURN);
    return d[63] ? -fx_t'(m[63:0]) : fx_t'(m[63:0]);
  endfunction

  // CORDIC rotation; angles past a quarter turn are folded, cosine negated
  task automatic sin_cos(input fx_t deg, output fx_t s, output fx_t c);
    fx_t x, y, z, dx, dy;
    bit  flip;
    flip = 1'b0;
    if (deg > QUARTER) begin
      deg  = HALF_TURN - deg;
      flip = 1'b1;
    end else if (deg < -QUARTER) begin
      deg  = -HALF_TURN - deg;
      flip = 1'b1;
    end
    x = gain_q;
    y = '0;
    z = deg_to_q61(deg);
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_q[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_q[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  task automatic to_ecef(input fx_t lat, input fx_t lon, input fx_t alt, output ecef_t g);
    fx_t w, nrad, h16, q;
    sin_cos(lat, g.sl, g.cl);
    sin_cos(lon, g.so, g.co);
    w    = ONE - mul_q(ecc2_q, mul_q(g.sl, g.sl, 61), 61);
    nrad = mul_q(SEMI_MAJ, inv_sqrt(w, ONE), 61);
    h16  = alt * 65536;
    q    = mul_q(nrad + h16, g.cl, 61);
    g.x  = mul_q(q, g.co, 61);
    g.y  = mul_q(q, g.so, 61);
    g.z  = mul_q(mul_q(nrad, ONE - ecc2_q, 61) + h16, g.sl, 61);
  endtask

  // Q16 to whole mm with clamping
  function automatic logic signed [35:0] round_clamp(input fx_t v, inout logic sat);
    fx_t r;
    r = (v + 64'sd32768) >>> 16;
    if (r > LIMIT_MM) begin
      r = LIMIT_MM; sat = 1'b1;
    end
    if (r < -LIMIT_MM) begin
      r = -LIMIT_MM; sat = 1'b1;
    end
    return r[35:0];
  endfunction

  task automatic predict_enu(input logic [95:0] d, output enu_t res);
    ecef_t p, o;
    fx_t   ddx, ddy, ddz, t, e, n, u;
    to_ecef(fx_t'($signed(d[30:0])), fx_t'($signed(d[62:31])),
            fx_t'($signed(d[90:63])), p);
    to_ecef(org_lat, org_lon, org_alt, o);
    ddx = p.x - o.x;
    ddy = p.y - o.y;
    ddz = p.z - o.z;
    t = mul_q(ddx, o.co, 61) + mul_q(ddy, o.so, 61);
    e = mul_q(ddy, o.co, 61) - mul_q(ddx, o.so, 61);
    n = mul_q(ddz, o.cl, 61) - mul_q(t, o.sl, 61);
    u = mul_q(t, o.cl, 61) + mul_q(ddz, o.sl, 61);
    res.sat   = 1'b0;
    res.east  = round_clamp(e, res.sat);
    res.north = round_clamp(n, res.sat);
    res.up    = round_clamp(u, res.sat);
  endtask

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // constant tables
  initial begin
    fx_t          p, sum, flat;
    int           k, sh;
    logic [127:0] fq;
    errors  = 0;
    pending = 0;
    org_lat = 64'sd374496400;
    org_lon = 64'sd1266566100;
    org_alt = 64'sd147674;
    atan_q[0] = PI >>> 2;
    for (int i = 1; i < STAGES; i++) begin
      sum = '0;
      k   = 0;
      sh  = i;
      while (sh <= 61) begin
        sum = k[0] ? sum - (ONE >>> sh) / fx_t'(2 * k + 1)
                   : sum + (ONE >>> sh) / fx_t'(2 * k + 1);
        k++;
        sh = i * (2 * k + 1);
      end
      atan_q[i] = sum;
    end
    p = ONE;
    for (int i = 0; i < STAGES; i++) p = p + (p >>> (2 * i));
    gain_q = inv_sqrt(p, (ONE / 10) * 6);
    fq     = ((128'd1 << 61) * 128'd1000000000) / 128'd298257223563;
    flat   = fx_t'(fq[63:0]);
    ecc2_q = 2 * flat - mul_q(flat, flat, 61);
  end

  // channel monitor
  always @(posedge clk) begin
    enu_t exp_r;
    if (rst) begin
      org_lat <= 64'sd374496400;
      org_lon <= 64'sd1266566100;
      org_alt <= 64'sd147674;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_LAT: org_lat <= fx_t'($signed(pwdata[30:0]));
          ADDR_LON: org_lon <= fx_t'($signed(pwdata[31:0]));
          ADDR_ALT: org_alt <= fx_t'($signed(pwdata[27:0]));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_enu(s_tdata, exp_r);
        enu_queue.push_back(exp_r);
      end
      if (m_tvalid && m_tready) begin
        if (enu_queue.size() == 0) begin
          report("result transfer with no point outstanding");
        end else begin
          exp_r = enu_queue.pop_front();
          if (m_tdata[35:0] !== exp_r.east)
            report($sformatf("east %0d, want %0d", $signed(m_tdata[35:0]), exp_r.east));
          if (m_tdata[71:36] !== exp_r.north)
            report($sformatf("north %0d, want %0d", $signed(m_tdata[71:36]), exp_r.north));
          if (m_tdata[107:72] !== exp_r.up)
            report($sformatf("up %0d, want %0d", $signed(m_tdata[107:72]), exp_r.up));
          if (m_tuser !== exp_r.sat)
            report($sformatf("saturated %b, want %b", m_tuser, exp_r.sat));
        end
      end
    end
    pending = enu_queue.size();
  end

endmodule

@@ verif/geodetic_to_enu_converter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_enu_converter_unit_tb: stimulus and verdict for the converter
// Runs directed and random points through several origin settings with
// random gaps and output stalls, including one long output hold-off that
// backs up the pipeline. Checking is done by enu_result_checker.
// ----------------------------------------------------------------------------
module geodetic_to_enu_converter_unit_tb;

  localparam logic [3:0] ADDR_LAT = 4'd0;
  localparam logic [3:0] ADDR_LON = 4'd4;
  localparam logic [3:0] ADDR_ALT = 4'd8;
  localparam int         LATENCY  = 98;
  localparam int         PHASES   = 7;
  localparam int         PER_PHASE = 125;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           pending;
  int           errors;

  // origin currently loaded, used to aim points nearby
  int           cur_lat = 374496400;
  int           cur_lon = 1266566100;
  int           cur_alt = 147674;

  always #5 clk = ~clk;

  geodetic_to_enu_converter_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  enu_result_checker #(
    .ADDR_LAT(ADDR_LAT), .ADDR_LON(ADDR_LON), .ADDR_ALT(ADDR_ALT)
  ) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .pending(pending), .errors(errors)
  );

  // register write: setup cycle then access cycle
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_origin(input int lat, input int lon, input int alt);
    apb_write(ADDR_LAT, 32'(lat));
    apb_write(ADDR_LON, 32'(lon));
    apb_write(ADDR_ALT, 32'(alt));
    cur_lat = $signed(31'(lat));
    cur_lon = lon;
    cur_alt = $signed(28'(alt));
  endtask

  // one point transfer; valid stays high across back-to-back points
  task automatic send_point(input int lat, input int lon, input int alt);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {5'd0, 28'(alt), 32'(lon), 31'(lat)};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_random_point();
    int lat, lon, alt;
    case ($urandom_range(0, 4))
      0, 1: begin
        // within a few km of the origin
        lat = cur_lat + $signed($urandom_range(0, 400000)) - 200000;
        lon = cur_lon + $signed($urandom_range(0, 400000)) - 200000;
        alt = cur_alt + $signed($urandom_range(0, 2000000)) - 1000000;
      end
      2: begin
        // anywhere on the valid globe
        lat = $signed($urandom_range(0, 1800000000)) - 900000000;
        lon = $signed($urandom_range(0, 2000000000)) - 1000000000;
        lon = lon + $signed($urandom_range(0, 1600000000)) - 800000000;
        alt = $signed($urandom_range(0, 200000000)) - 100000000;
      end
      default: begin
        // raw field bits, past the poles and dateline included
        lat = $urandom;
        lon = $urandom;
        alt = $urandom;
      end
    endcase
    send_point(lat, lon, alt);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off to fill the pipeline
  initial begin
    int w;
    int n;
    n = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n++;
      w = (n == 120) ? 400 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16));
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed points at the reset origin
    send_point(374496400, 1266566100, 147674);
    send_point(0, 0, 0);
    send_point(900000000, 0, 0);
    send_point(-900000000, 0, 0);
    send_point(900000001, 450000000, 1000);
    send_point(-900000001, -450000000, -1000);
    send_point(32'h3FFF_FFFF, 1800000000, 100000000);
    send_point(32'hC000_0000, -1800000000, -100000000);
    send_point(0, 32'h7FFF_FFFF, 28'h7FF_FFFF);
    send_point(0, 32'h8000_0000, 28'h800_0000);
    send_point(374496401, 1266566099, 147675);
    send_point(-1, -1, -1);
    send_point(450000000, 900000000, 0);
    send_point(-450000000, -900000000, 0);
    for (int i = 0; i < PER_PHASE; i++) send_random_point();
    drain();

    // origin sweeps, field extremes among them
    for (int ph = 0; ph < PHASES - 1; ph++) begin
      case (ph)
        0: set_origin(0, 0, 0);
        1: set_origin(32'h3FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF);
        2: set_origin(32'hC000_0000, 32'h8000_0000, 28'h800_0000);
        3: set_origin(900000000, 1800000000, 100000000);
        4: set_origin(-900000000, -1800000000, -100000000);
        default: set_origin($signed($urandom_range(0, 1800000000)) - 900000000,
                            $urandom, $signed($urandom_range(0, 2000000)) - 1000000);
      endcase
      for (int i = 0; i < PER_PHASE; i++) send_random_point();
      drain();
    end

    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
